@@ hdl/quoted_field_tokenizer_top_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef QUOTED_FIELD_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_FIELD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define QFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define QFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qft_pkg.sv @@
// Shared types and constants for the quoted field tokenizer.
// No dependencies; imported by every module of the block.
package qft_pkg;

  // Protecting byte (backslash)
  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_DELIMITER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WHITESPACE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_QUOTE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPRESS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNESCAPE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIM = 3'd5;

  // Register reset values (widened to 64 bits, cut down to slot storage)
  localparam logic [63:0] DELIMITER_RESET = 64'd44;
  localparam logic [63:0] WHITESPACE_RESET = 64'd2336;
  localparam logic [63:0] QUOTE_RESET = 64'd10018;

  // Slots that the register widths can hold at most
  localparam int unsigned DELIM_MAX = 4;
  localparam int unsigned SPACE_MAX = 8;
  localparam int unsigned QUOTE_MAX = 2;

  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [15:0] TRAIL_MAX = 16'hFFFF;

  // Result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // Single-bit mode registers
  typedef struct packed {
    logic compress_empty;
    logic unescape_mode;
    logic trim_mode;
  } mode_t;

  // One result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] drop_tail;
    logic        empty_token;
    logic        string_done;
  } result_t;

  // All results caused by one input byte (count is 1..3 when queued)
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } bundle_t;

  function automatic result_t mk_res(logic kind, logic [7:0] b, logic [15:0] drop,
                                     logic empty, logic done);
    result_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.drop_tail   = drop;
    r.empty_token = empty;
    r.string_done = done;
    return r;
  endfunction

endpackage

@@ hdl/qft_front.sv @@
// Front end: accepts input bytes, classifies them and updates the tokenizer state.
// Produces a bundle of up to three results per byte. Depends on qft_pkg.
module qft_front #(
  parameter int unsigned DELIM_N = 4,
  parameter int unsigned SPACE_N = 8,
  parameter int unsigned QUOTE_N = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tlast,
  input  logic [DELIM_N*8-1:0]  delimiter_chars,
  input  logic [SPACE_N*8-1:0]  whitespace_chars,
  input  logic [QUOTE_N*8-1:0]  quote_chars,
  input  qft_pkg::mode_t        mode,
  input  logic                  q_full,
  output logic                  push,
  output qft_pkg::bundle_t      push_bundle
);
  import qft_pkg::*;

  // Tokenizer state
  logic [7:0]  open_quote, open_quote_next;
  logic        escape_pending, escape_pending_next;
  logic        token_started, token_started_next;
  logic [15:0] trailing_count, trailing_count_next;
  logic        any_token_ended, any_token_ended_next;

  logic        accept;
  logic        is_delim, is_quote, is_space;
  logic        keep_bs, tok_empty;
  logic [1:0]  n;
  logic [7:0]  b;
  bundle_t     bnd;

  assign b        = s_tdata;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Set membership, zero slots unused
  always_comb begin
    is_delim = 1'b0;
    is_space = 1'b0;
    is_quote = 1'b0;
    for (int i = 0; i < DELIM_N; i++) begin
      if (delimiter_chars[8*i +: 8] != 8'd0 && delimiter_chars[8*i +: 8] == b) is_delim = 1'b1;
    end
    for (int i = 0; i < SPACE_N; i++) begin
      if (whitespace_chars[8*i +: 8] != 8'd0 && whitespace_chars[8*i +: 8] == b) is_space = 1'b1;
    end
    for (int i = 0; i < QUOTE_N; i++) begin
      if (quote_chars[8*i +: 8] != 8'd0 && quote_chars[8*i +: 8] == b) is_quote = 1'b1;
    end
  end

  // Per-byte results and next state
  always_comb begin
    open_quote_next      = open_quote;
    escape_pending_next  = escape_pending;
    token_started_next   = token_started;
    trailing_count_next  = trailing_count;
    any_token_ended_next = any_token_ended;
    bnd                  = '0;
    n                    = 2'd0;
    keep_bs              = 1'b1;
    tok_empty            = 1'b0;

    if (escape_pending) begin
      // protected byte, backslash kept unless unescape removes it
      escape_pending_next = 1'b0;
      if (mode.unescape_mode) begin
        if (open_quote == 8'd0) begin
          keep_bs = !(b == ESCAPE_BYTE || is_quote || is_delim || is_space);
        end else begin
          keep_bs = !(b == ESCAPE_BYTE || b == open_quote);
        end
      end
      if (keep_bs) begin
        bnd.res[n] = mk_res(1'b0, ESCAPE_BYTE, 16'd0, 1'b0, 1'b0);
        n = n + 2'd1;
      end
      bnd.res[n] = mk_res(1'b0, b, 16'd0, 1'b0, 1'b0);
      n = n + 2'd1;
      token_started_next  = 1'b1;
      trailing_count_next = 16'd0;
    end else if (b == ESCAPE_BYTE) begin
      escape_pending_next = 1'b1;
    end else if (open_quote == 8'd0 && is_delim) begin
      // unquoted delimiter ends the token
      tok_empty = !token_started_next;
      if (!tok_empty || !mode.compress_empty || !any_token_ended_next) begin
        bnd.res[n] = mk_res(1'b1, 8'd0, trailing_count_next, tok_empty, 1'b0);
        n = n + 2'd1;
        any_token_ended_next = 1'b1;
      end
      token_started_next  = 1'b0;
      trailing_count_next = 16'd0;
      open_quote_next     = 8'd0;
      escape_pending_next = 1'b0;
      if (s_tlast) begin
        // final delimiter adds an empty token
        bnd.res[n] = mk_res(1'b1, 8'd0, 16'd0, 1'b1, 1'b1);
        n = n + 2'd1;
        any_token_ended_next = 1'b0;
      end
    end else if (open_quote != 8'd0 && b == open_quote) begin
      open_quote_next     = 8'd0;
      trailing_count_next = 16'd0;
      if (!mode.unescape_mode) begin
        bnd.res[n] = mk_res(1'b0, b, 16'd0, 1'b0, 1'b0);
        n = n + 2'd1;
        token_started_next = 1'b1;
      end
    end else if (open_quote == 8'd0 && is_quote) begin
      open_quote_next     = b;
      trailing_count_next = 16'd0;
      if (!mode.unescape_mode) begin
        bnd.res[n] = mk_res(1'b0, b, 16'd0, 1'b0, 1'b0);
        n = n + 2'd1;
        token_started_next = 1'b1;
      end
    end else if (mode.trim_mode && open_quote == 8'd0 && is_space) begin
      // leading space skipped, trailing space counted
      if (token_started) begin
        if (trailing_count != TRAIL_MAX) trailing_count_next = trailing_count + 16'd1;
        bnd.res[n] = mk_res(1'b0, b, 16'd0, 1'b0, 1'b0);
        n = n + 2'd1;
      end
    end else begin
      trailing_count_next = 16'd0;
      bnd.res[n] = mk_res(1'b0, b, 16'd0, 1'b0, 1'b0);
      n = n + 2'd1;
      token_started_next = 1'b1;
    end

    // End of string, unless the delimiter path has closed it already
    if (s_tlast && !(!escape_pending && b != ESCAPE_BYTE && open_quote == 8'd0 && is_delim)) begin
      if (escape_pending_next) begin
        // dangling backslash is content
        trailing_count_next = 16'd0;
        bnd.res[n] = mk_res(1'b0, ESCAPE_BYTE, 16'd0, 1'b0, 1'b0);
        n = n + 2'd1;
        token_started_next = 1'b1;
      end
      tok_empty = !token_started_next;
      if (!tok_empty || !mode.compress_empty || !any_token_ended_next) begin
        bnd.res[n] = mk_res(1'b1, 8'd0, trailing_count_next, tok_empty, 1'b1);
        n = n + 2'd1;
      end
      open_quote_next      = 8'd0;
      escape_pending_next  = 1'b0;
      token_started_next   = 1'b0;
      trailing_count_next  = 16'd0;
      any_token_ended_next = 1'b0;
    end
    bnd.count = n;
  end

  assign push        = accept && (n != 2'd0);
  assign push_bundle = bnd;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_quote      <= 8'd0;
      escape_pending  <= 1'b0;
      token_started   <= 1'b0;
      trailing_count  <= 16'd0;
      any_token_ended <= 1'b0;
    end else if (accept) begin
      open_quote      <= open_quote_next;
      escape_pending  <= escape_pending_next;
      token_started   <= token_started_next;
      trailing_count  <= trailing_count_next;
      any_token_ended <= any_token_ended_next;
    end
  end

endmodule

@@ hdl/qft_queue.sv @@
// Short FIFO of result bundles between the front and back ends.
// Depends on qft_pkg and the shared assertion macros.
`include "quoted_field_tokenizer_top_defines.svh"

module qft_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qft_pkg::bundle_t push_data,
  output logic             full,
  output logic             head_valid,
  output qft_pkg::bundle_t head_data,
  input  logic             pop
);
  import qft_pkg::*;

  bundle_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full       = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `QFT_ASSERT_NOW(a_no_overflow, push, !full, "bundle pushed into a full queue")
  `QFT_ASSERT_NOW(a_no_underflow, pop, count != '0, "bundle popped from an empty queue")

endmodule

@@ hdl/qft_back.sv @@
// Back end: walks each queued bundle and drives one result per output transaction.
// Output register holds the current result; m_tready reaches pop combinationally. Depends on qft_pkg and macros.
`include "quoted_field_tokenizer_top_defines.svh"

module qft_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  qft_pkg::bundle_t head_data,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // out_byte[7:0], drop_tail[23:8], empty_token[24], zero
  output logic             m_tuser,   // kind
  output logic             m_tlast
);
  import qft_pkg::*;

  logic [1:0] idx;
  logic       load;
  result_t    out_res;

  // Take the next result when the output register is free or being drained
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && (idx == (head_data.count - 2'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= pop ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) out_res <= head_data.res[idx];
  end

  assign m_tdata = {7'd0, out_res.empty_token, out_res.drop_tail, out_res.out_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.string_done;

  `QFT_ASSERT_NOW(a_idx_in_bundle, head_valid,
    head_data.count != 2'd0 && idx < head_data.count, "result index past bundle end")
  `QFT_ASSERT_NEXT(a_idx_restart, pop, idx == 2'd0, "index not rewound after bundle")

endmodule

@@ hdl/quoted_field_tokenizer_top.sv @@
// Quoted field tokenizer: one source byte per input transaction in, token bytes and
// end-of-token marks out. Depends on qft_pkg, qft_front, qft_queue and qft_back.
//
// A new byte is accepted every cycle while the four-entry result queue has room;
// each byte yields zero to three result transactions, and the output port issues one
// result per cycle while m_tready is high, so bytes giving at most one result flow at
// one per cycle and the output port sets the rate otherwise. First result of a byte
// passes through the result queue and the output register. Configuration writes take
// effect on the next byte and must be made while no results are outstanding.
module quoted_field_tokenizer_top #(
  parameter int unsigned DELIM_SLOTS = 4,
  parameter int unsigned SPACE_SLOTS = 8,
  parameter int unsigned QUOTE_SLOTS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,    // data_byte[7:0]
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,    // out_byte, drop_tail, empty_token
  output logic                            m_tuser,    // kind
  output logic                            m_tlast,
  input  logic                            cfg_wen,
  input  logic [qft_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [qft_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import qft_pkg::*;

  // Only slots that the register width can hold are stored
  localparam int unsigned DELIM_N = (DELIM_SLOTS < DELIM_MAX) ? DELIM_SLOTS : DELIM_MAX;
  localparam int unsigned SPACE_N = (SPACE_SLOTS < SPACE_MAX) ? SPACE_SLOTS : SPACE_MAX;
  localparam int unsigned QUOTE_N = (QUOTE_SLOTS < QUOTE_MAX) ? QUOTE_SLOTS : QUOTE_MAX;

  logic [DELIM_N*8-1:0] delimiter_chars;
  logic [SPACE_N*8-1:0] whitespace_chars;
  logic [QUOTE_N*8-1:0] quote_chars;
  mode_t                mode;

  logic    q_full, push, pop, head_valid;
  bundle_t push_bundle, head_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_chars     <= DELIMITER_RESET[DELIM_N*8-1:0];
      whitespace_chars    <= WHITESPACE_RESET[SPACE_N*8-1:0];
      quote_chars         <= QUOTE_RESET[QUOTE_N*8-1:0];
      mode.compress_empty <= 1'b0;
      mode.unescape_mode  <= 1'b1;
      mode.trim_mode      <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_DELIMITER:  delimiter_chars     <= cfg_wdata[DELIM_N*8-1:0];
        REG_WHITESPACE: whitespace_chars    <= cfg_wdata[SPACE_N*8-1:0];
        REG_QUOTE:      quote_chars         <= cfg_wdata[QUOTE_N*8-1:0];
        REG_COMPRESS:   mode.compress_empty <= cfg_wdata[0];
        REG_UNESCAPE:   mode.unescape_mode  <= cfg_wdata[0];
        REG_TRIM:       mode.trim_mode      <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  qft_front #(
    .DELIM_N (DELIM_N),
    .SPACE_N (SPACE_N),
    .QUOTE_N (QUOTE_N)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .delimiter_chars  (delimiter_chars),
    .whitespace_chars (whitespace_chars),
    .quote_chars      (quote_chars),
    .mode             (mode),
    .q_full           (q_full),
    .push             (push),
    .push_bundle      (push_bundle)
  );

  qft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_bundle),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  qft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking bench for quoted_field_tokenizer_top: byte stream in, token results out.
// Depends on qft_pkg and the tokenizer RTL; holds its own tokenizer model for prediction.
`timescale 1ns / 100ps

module tb;
  import qft_pkg::*;

  localparam int NUM_DELIM = 4;
  localparam int NUM_SPACE = 8;
  localparam int NUM_QUOTE = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration registers
  logic [31:0] delim_set = 32'(DELIMITER_RESET);
  logic [63:0] space_set = WHITESPACE_RESET;
  logic [15:0] quote_set = 16'(QUOTE_RESET);
  logic compress_on = 1'b0;
  logic unescape_on = 1'b1;
  logic trim_on = 1'b1;

  // Tokenizer model state
  logic [7:0] open_q = '0;
  logic esc_pending = 1'b0;
  logic tok_started = 1'b0;
  logic [15:0] trail_cnt = '0;
  logic any_ended = 1'b0;

  src_byte_t src_bytes_q[$];
  result_t token_results_q[$];
  src_byte_t nxt_byte;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_cycle = 0;
  int err_count = 0;

  quoted_field_tokenizer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("tb: mismatch at %0t ns: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  function automatic logic in_slots(logic [63:0] slots, int n, logic [7:0] b);
    for (int i = 0; i < n; i++) begin
      if (slots[8*i +: 8] != 8'h00 && slots[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_result(logic kind, logic [7:0] b, logic [15:0] drop,
                                     logic empty, logic done);
    result_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.drop_tail   = drop;
    r.empty_token = empty;
    r.string_done = done;
    token_results_q.insert(token_results_q.size(), r);
  endfunction

  function automatic void emit_content(logic [7:0] b);
    add_result(1'b0, b, 16'h0, 1'b0, 1'b0);
    tok_started = 1'b1;
  endfunction

  // Close the current token; compression swallows empties after the first token
  function automatic void close_token(logic done);
    logic empty;
    empty = !tok_started;
    if (!empty || !compress_on || !any_ended) begin
      add_result(1'b1, 8'h00, trail_cnt, empty, done);
      any_ended = 1'b1;
    end
    tok_started = 1'b0;
    trail_cnt   = '0;
    open_q      = '0;
    esc_pending = 1'b0;
  endfunction

  function automatic void clear_string();
    open_q      = '0;
    esc_pending = 1'b0;
    tok_started = 1'b0;
    trail_cnt   = '0;
    any_ended   = 1'b0;
  endfunction

  // Work out every result one accepted byte causes
  function automatic void tokenize_byte(logic [7:0] b, logic last);
    logic is_delim, is_quote, is_space, keep_bs;
    is_delim = in_slots(64'(delim_set), NUM_DELIM, b);
    is_quote = in_slots(64'(quote_set), NUM_QUOTE, b);
    is_space = in_slots(space_set, NUM_SPACE, b);
    if (esc_pending) begin
      esc_pending = 1'b0;
      keep_bs = 1'b1;
      if (unescape_on) begin
        if (open_q == 8'h00)
          keep_bs = !(b == ESCAPE_BYTE || is_quote || is_delim || is_space);
        else
          keep_bs = !(b == ESCAPE_BYTE || b == open_q);
      end
      if (keep_bs) emit_content(ESCAPE_BYTE);
      emit_content(b);
      trail_cnt = '0;
    end else if (b == ESCAPE_BYTE) begin
      esc_pending = 1'b1;
    end else if (open_q == 8'h00 && is_delim) begin
      close_token(1'b0);
      // final delimiter adds an empty token
      if (last) begin
        add_result(1'b1, 8'h00, 16'h0, 1'b1, 1'b1);
        clear_string();
      end
      return;
    end else if (open_q != 8'h00 && b == open_q) begin
      open_q = '0;
      trail_cnt = '0;
      if (!unescape_on) emit_content(b);
    end else if (open_q == 8'h00 && is_quote) begin
      open_q = b;
      trail_cnt = '0;
      if (!unescape_on) emit_content(b);
    end else if (trim_on && open_q == 8'h00 && is_space) begin
      if (tok_started) begin
        if (trail_cnt != TRAIL_MAX) trail_cnt++;
        emit_content(b);
      end
    end else begin
      trail_cnt = '0;
      emit_content(b);
    end
    if (last) begin
      // dangling backslash is plain content
      if (esc_pending) begin
        esc_pending = 1'b0;
        trail_cnt = '0;
        emit_content(ESCAPE_BYTE);
      end
      close_token(1'b1);
      clear_string();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: bursts of transactions with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (src_bytes_q.size() != 0) begin
          nxt_byte = src_bytes_q.pop_front();
          s_tdata  <= nxt_byte.data;
          s_tlast  <= nxt_byte.last;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern, long hold on request, field checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_results_q.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: kind %0b data %h last %0b",
                                  m_tuser, m_tdata, m_tlast));
        end else begin
          want = token_results_q.pop_front();
          if (m_tuser !== want.kind)
            flag_mismatch($sformatf("kind %0b, want %0b", m_tuser, want.kind));
          if (m_tdata[7:0] !== want.out_byte)
            flag_mismatch($sformatf("out_byte %h, want %h", m_tdata[7:0], want.out_byte));
          if (m_tdata[23:8] !== want.drop_tail)
            flag_mismatch($sformatf("drop_tail %0d, want %0d", m_tdata[23:8],
                                    want.drop_tail));
          if (m_tdata[24] !== want.empty_token)
            flag_mismatch($sformatf("empty_token %0b, want %0b", m_tdata[24],
                                    want.empty_token));
          if (m_tlast !== want.string_done)
            flag_mismatch($sformatf("string_done %0b, want %0b", m_tlast,
                                    want.string_done));
          if (m_tdata[31:25] !== '0)
            flag_mismatch($sformatf("pad bits %h not zero", m_tdata[31:25]));
        end
      end
      stall_cycle++;
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (stall_cycle[7:6])
          2'd0: m_tready <= 1'b1;
          2'd1: m_tready <= ($urandom_range(0, 3) != 0);
          2'd2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= stall_cycle[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DELIMITER:  delim_set = val[31:0];
      REG_WHITESPACE: space_set = val;
      REG_QUOTE:      quote_set = val[15:0];
      REG_COMPRESS:   compress_on = val[0];
      REG_UNESCAPE:   unescape_on = val[0];
      REG_TRIM:       trim_on = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    src_byte_t item;
    item.data = b;
    item.last = last;
    src_bytes_q.insert(src_bytes_q.size(), item);
    bytes_queued++;
  endtask

  task automatic push_text(input string s, input logic ends_string);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], ends_string && (i == s.len() - 1));
  endtask

  // Bytes weighted toward the active delimiter, space and quote slots
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 11))
      0, 1: v = delim_set[8*$urandom_range(0, NUM_DELIM-1) +: 8];
      2, 3: v = space_set[8*$urandom_range(0, NUM_SPACE-1) +: 8];
      4:    v = quote_set[8*$urandom_range(0, NUM_QUOTE-1) +: 8];
      5:    v = ESCAPE_BYTE;
      6, 7, 8, 9: v = 8'h61 + 8'($urandom_range(0, 5));
      default: v = 8'($urandom_range(1, 255));
    endcase
    if (v == 8'h00) v = 8'($urandom_range(1, 255));
    return v;
  endfunction

  // Random slot contents drawn from a small alphabet so they get hit
  function automatic logic [63:0] rand_slots();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 7))
        0: v[8*i +: 8] = 8'h00;
        1: v[8*i +: 8] = ",";
        2: v[8*i +: 8] = " ";
        3: v[8*i +: 8] = "\"";
        4: v[8*i +: 8] = "'";
        5: v[8*i +: 8] = "a";
        6: v[8*i +: 8] = "|";
        default: v[8*i +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    return v;
  endfunction

  // Strings of random length; a phase may end in the middle of one
  task automatic queue_random_phase(input int n);
    int left;
    left = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      left--;
      push_byte(pick_byte(), left == 0);
      if (left == 0) left = $urandom_range(1, 12);
    end
  endtask

  // Sender stops until every byte is taken and every result is back
  task automatic drain();
    while (bytes_taken != bytes_queued || token_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_modes(input logic comp, input logic unesc, input logic trim);
    write_reg(REG_COMPRESS, 64'(comp));
    write_reg(REG_UNESCAPE, 64'(unesc));
    write_reg(REG_TRIM, 64'(trim));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: skipped leading space, escaped delimiter, trailing space, quoted
    // delimiter, escaped closing quote, final delimiter, lone backslash, other
    // quote inside a span, kept backslash, top byte value
    push_text("\t a\\,b , \"x,\\\"y\" ,", 1'b1);
    push_text("\\", 1'b1);
    push_text("'\"'\\q", 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();

    // Mixed slots with an unused one, compression on; long receiver hold
    write_reg(REG_DELIMITER, 64'h3B7C_2C00);
    write_reg(REG_WHITESPACE, 64'h0D0A_0920);
    write_reg(REG_QUOTE, 64'h2722);
    set_modes(1'b1, 1'b1, 1'b1);
    queue_random_phase(30);
    hold_req++;
    drain();

    // All registers at zero, writes to unused indexes ignored
    write_reg(REG_DELIMITER, 64'h0);
    write_reg(REG_WHITESPACE, 64'h0);
    write_reg(REG_QUOTE, 64'h0);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    set_modes(1'b0, 1'b0, 1'b0);
    queue_random_phase(20);
    drain();

    // All registers at their maximum: 0xFF is delimiter, quote and space at once
    write_reg(REG_DELIMITER, 64'hFFFF_FFFF);
    write_reg(REG_WHITESPACE, '1);
    write_reg(REG_QUOTE, 64'hFFFF);
    set_modes(1'b1, 1'b1, 1'b1);
    queue_random_phase(20);
    drain();

    // Reset-style sets, pass-through escapes with compression
    write_reg(REG_DELIMITER, DELIMITER_RESET);
    write_reg(REG_WHITESPACE, WHITESPACE_RESET);
    write_reg(REG_QUOTE, QUOTE_RESET);
    set_modes(1'b1, 1'b0, 1'b1);
    queue_random_phase(20);
    hold_req++;
    drain();

    // Random sets and modes
    for (int p = 0; p < 2; p++) begin
      write_reg(REG_DELIMITER, rand_slots());
      write_reg(REG_WHITESPACE, rand_slots());
      write_reg(REG_QUOTE, rand_slots());
      set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      queue_random_phase(18);
      drain();
    end

    // Defaults with trimming off
    write_reg(REG_DELIMITER, DELIMITER_RESET);
    write_reg(REG_WHITESPACE, WHITESPACE_RESET);
    write_reg(REG_QUOTE, QUOTE_RESET);
    set_modes(1'b0, 1'b1, 1'b0);
    queue_random_phase(20);
    drain();

    // Short trailing run at string end
    set_modes(1'b0, 1'b1, 1'b1);
    push_text("b  ", 1'b1);

    // Wrap-up: all accepted, then a bounded wait for the remaining results
    while (bytes_taken != bytes_queued) @(posedge clk);
    waited = 0;
    while (token_results_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (token_results_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", token_results_q.size()));
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

endmodule
